[hdl/tcsd_pkg.sv]
package tcsd_pkg;

	typedef logic [3:0] bcd_t;
	typedef bcd_t [3:0] digits_t;  // [0] hour tens .. [3] minute ones

	localparam logic [6:0] TICK_MAX     = 7'd127;
	localparam logic [6:0] TPS_RESET    = 7'd20;
	localparam logic [5:0] SEC_WRAP     = 6'd60;
	localparam bcd_t       DIGIT_MAX    = 4'd9;
	localparam bcd_t       TENS_TIMER   = 4'd6;
	localparam bcd_t       TENS_COUNTER = 4'd10;

	typedef struct packed {
		logic tick;
		logic run_on;
		logic timer_mode;
		logic pulse_level;
	} in_item_t;

	// what the display stage needs from the updated state
	typedef struct packed {
		bcd_t       digit;
		logic       dp_n;
		logic [1:0] slot;
	} disp_t;

	localparam logic [7:0] SEG_CODE [16] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
	};

	// ripple one count through the four digits; tens_limit wraps digit 2
	function automatic digits_t advance_digits(digits_t d, bcd_t tens_limit);
		digits_t r;
		r = d;
		if (d[3] != DIGIT_MAX) begin
			r[3] = d[3] + 4'd1;
		end else begin
			r[3] = '0;
			if (d[2] + 4'd1 < tens_limit) begin
				r[2] = d[2] + 4'd1;
			end else begin
				r[2] = '0;
				if (d[1] != DIGIT_MAX) begin
					r[1] = d[1] + 4'd1;
				end else begin
					r[1] = '0;
					r[0] = (d[0] >= DIGIT_MAX) ? 4'd0 : d[0] + 4'd1;
				end
			end
		end
		return r;
	endfunction

endpackage

[hdl/tcsd_engine.sv]
module tcsd_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  tcsd_pkg::in_item_t item,
	input  logic [6:0]        tps,
	output tcsd_pkg::disp_t   disp
);
	import tcsd_pkg::*;

	digits_t    digits_q, digits_d;
	logic [5:0] sec_q, sec_d;
	logic [6:0] acc_q, acc_d;
	logic       timer_q, timer_d;
	logic       armed_q, armed_d;
	logic [1:0] slot_q;

	always_comb begin
		digits_d = digits_q;
		sec_d    = sec_q;
		timer_d  = timer_q;
		armed_d  = armed_q;
		acc_d    = (item.tick && acc_q < TICK_MAX) ? acc_q + 7'd1 : acc_q;

		if (item.run_on) begin
			if (item.timer_mode) begin
				if (!timer_q) begin
					timer_d  = 1'b1;
					digits_d = '0;
					sec_d    = '0;
					acc_d    = '0;
				end
				if (acc_d >= tps) begin
					acc_d = acc_d - tps;
					if (sec_d + 6'd1 >= SEC_WRAP) begin
						sec_d    = '0;
						digits_d = advance_digits(digits_d, TENS_TIMER);
					end else begin
						sec_d = sec_d + 6'd1;
					end
				end
			end else begin
				if (timer_q) begin
					timer_d  = 1'b0;
					digits_d = '0;
					sec_d    = '0;
				end
				// count on the first high level after a low
				if (armed_q) begin
					if (item.pulse_level) begin
						armed_d  = 1'b0;
						digits_d = advance_digits(digits_d, TENS_COUNTER);
					end
				end else if (!item.pulse_level) begin
					armed_d = 1'b1;
				end
			end
		end

		disp.digit = digits_d[slot_q];
		disp.dp_n  = ~sec_d[0];
		disp.slot  = slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			sec_q    <= '0;
			acc_q    <= '0;
			timer_q  <= 1'b1;
			armed_q  <= 1'b1;
			slot_q   <= '0;
		end else if (fire) begin
			digits_q <= digits_d;
			sec_q    <= sec_d;
			acc_q    <= acc_d;
			timer_q  <= timer_d;
			armed_q  <= armed_d;
			slot_q   <= slot_q + 2'd1;
		end
	end

endmodule

[hdl/timer_counter_segment_display_core.sv]
// Four-digit multiplexed seven-segment stopwatch / pulse counter.
// Input channel (in_valid / in_stall): one item per display scan slot,
// carrying the tick flag and the run, mode and pulse switch levels.
// Output channel (out_valid / out_stall): one item per input item with the
// active-low segment pattern and the one-cold digit enable of the slot.
// Config channel (cfg_valid / cfg_ready, always ready): writes
// ticks_per_second; write only while no items are in flight.
// An accepted item goes through the input register, then the state update and
// segment lookup into the output register, where out_valid rises.
// Throughput: one item per cycle unless stalled; the state update is a
// single pass of short logic between the input and output registers.
// Stall: when out_stall holds a full output register, the item in the input
// register waits and in_stall rises in the same cycle.
// Reset: digits, seconds and ticks clear, timer mode, pulse armed, scan
// slot 0, ticks_per_second 20; both pipeline registers empty.
module timer_counter_segment_display_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] ticks_per_second,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       tick,
	input  logic       run_on,
	input  logic       timer_mode,
	input  logic       pulse_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segments,
	output logic [3:0] digit_enable
);
	import tcsd_pkg::*;

	logic       tps_q;
	logic [6:0] tps_val_q;
	logic       valid_s1;
	in_item_t   item_s1;
	logic       advance;
	disp_t      disp;
	logic [7:0] seg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_val_q <= TPS_RESET;
		end else if (cfg_valid) begin
			tps_val_q <= ticks_per_second;
		end
	end
	assign tps_q = 1'b0;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{tick: tick, run_on: run_on, timer_mode: timer_mode,
				pulse_level: pulse_level};
		end
	end

	tcsd_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.tps    (tps_val_q | {7{tps_q}}),
		.disp   (disp)
	);

	always_comb begin
		seg    = SEG_CODE[disp.digit];
		seg[7] = disp.dp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			segments     <= seg;
			digit_enable <= ~(4'b0001 << disp.slot);
		end
	end

endmodule

[hdl/tcsd_checker.sv]
module tcsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] segments,
	input logic [3:0] digit_enable
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(segments) && $stable(digit_enable))
		else $error("stalled output item changed");

	a_one_cold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(digit_enable) == 3)
		else $error("digit enable not one-cold");

	// input side only stalls behind a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall |=> out_valid)
		else $error("accepted item did not reach the output");

endmodule

bind timer_counter_segment_display_core tcsd_checker u_tcsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.segments     (segments),
	.digit_enable (digit_enable)
);

[tb/timer_counter_segment_display_core_tb.sv]
module timer_counter_segment_display_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcsd_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 6;

	// active-low seven-segment patterns, hex digits 0..f
	localparam logic [7:0] SEG_PATTERN [16] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
	};

	typedef struct packed {
		logic [7:0] segments;
		logic [3:0] digit_enable;
	} shown_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [6:0] ticks_per_second = TPS_RESET;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       tick = 1'b0;
	logic       run_on = 1'b0;
	logic       timer_mode = 1'b0;
	logic       pulse_level = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] segments;
	logic [3:0] digit_enable;

	timer_counter_segment_display_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.ticks_per_second (ticks_per_second),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.tick             (tick),
		.run_on           (run_on),
		.timer_mode       (timer_mode),
		.pulse_level      (pulse_level),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.segments         (segments),
		.digit_enable     (digit_enable)
	);

	// display model state
	bcd_t       cnt_digit [4];
	logic [5:0] cnt_sec;
	logic [6:0] acc_ticks;
	logic       in_timer;
	logic       armed;
	logic [1:0] scan_pos;
	logic [6:0] tps_now;

	shown_t      display_q [$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned slots_sent = 0;
	int unsigned slots_shown = 0;
	int unsigned tps_writes = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// ripple one count from minute ones upward; digit 2 wraps at tens_lim
	function automatic void bump_count(input bcd_t tens_lim);
		bcd_t lim;
		for (int i = 3; i >= 0; i--) begin
			lim = (i == 2) ? tens_lim : 4'd10;
			if (cnt_digit[i] + 4'd1 < lim) begin
				cnt_digit[i] = cnt_digit[i] + 4'd1;
				return;
			end
			cnt_digit[i] = '0;
		end
	endfunction

	function automatic void clear_count();
		for (int i = 0; i < 4; i++)
			cnt_digit[i] = '0;
		cnt_sec = '0;
	endfunction

	function automatic void compute_display(input in_item_t it, output shown_t res);
		if (it.tick && acc_ticks != 7'd127)
			acc_ticks = acc_ticks + 7'd1;
		if (it.run_on) begin
			if (it.timer_mode) begin
				if (!in_timer) begin
					in_timer = 1'b1;
					clear_count();
					acc_ticks = '0;
				end
				if (acc_ticks >= tps_now) begin
					acc_ticks = acc_ticks - tps_now;
					cnt_sec = cnt_sec + 6'd1;
					if (cnt_sec >= 6'd60) begin
						cnt_sec = '0;
						bump_count(4'd6);
					end
				end
			end else begin
				if (in_timer) begin
					in_timer = 1'b0;
					clear_count();
				end
				if (armed) begin
					if (it.pulse_level) begin
						armed = 1'b0;
						bump_count(4'd10);
					end
				end else if (!it.pulse_level) begin
					armed = 1'b1;
				end
			end
		end
		res.segments = SEG_PATTERN[cnt_digit[scan_pos]];
		res.segments[7] = ~cnt_sec[0];
		res.digit_enable = ~(4'b0001 << scan_pos);
		scan_pos = scan_pos + 2'd1;
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		shown_t want;
		shown_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tps_now = ticks_per_second;
			if (in_valid && !in_stall) begin
				compute_display({tick, run_on, timer_mode, pulse_level}, want);
				display_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = '{segments, digit_enable};
				if (display_q.size() == 0) begin
					$display("%0t: unexpected item segments=%h digit_enable=%b",
						$time, segments, digit_enable);
					mismatches++;
				end else begin
					want = display_q.pop_front();
					slots_shown++;
					if (got.segments !== want.segments) begin
						$display("%0t: segments expected %h actual %h",
							$time, want.segments, got.segments);
						mismatches++;
					end
					if (got.digit_enable !== want.digit_enable) begin
						$display("%0t: digit_enable expected %b actual %b",
							$time, want.digit_enable, got.digit_enable);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("timer_counter_segment_display_core test failed");
				$finish;
			end
		end
	end

	task automatic send_slot(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			{tick, run_on, timer_mode, pulse_level} <= 4'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{tick, run_on, timer_mode, pulse_level} <= it;
		do @(posedge clk); while (in_stall);
		slots_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (slots_shown < slots_sent)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tps(input logic [6:0] rate);
		wait_drained();
		cfg_valid <= 1'b1;
		ticks_per_second <= rate;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tps_writes++;
	endtask

	// register at reset value, nothing running: zero display, slot cycling
	task automatic test_idle_scan();
		send_slot('{1'b0, 1'b0, 1'b0, 1'b0});
		send_slot('{1'b1, 1'b0, 1'b1, 1'b1});
		send_slot('{1'b0, 1'b0, 1'b0, 1'b0});
		send_slot('{1'b1, 1'b0, 1'b0, 1'b1});
		send_slot('{1'b0, 1'b0, 1'b1, 1'b0});
	endtask

	// mode entry clears, first high counts, held level does not, run off holds
	task automatic test_counter_edges();
		send_slot('{1'b0, 1'b1, 1'b0, 1'b1});
		send_slot('{1'b0, 1'b1, 1'b0, 1'b1});
		send_slot('{1'b1, 1'b1, 1'b0, 1'b0});
		send_slot('{1'b0, 1'b1, 1'b0, 1'b1});
		send_slot('{1'b0, 1'b0, 1'b0, 1'b0});
		send_slot('{1'b0, 1'b0, 1'b1, 1'b1});
		send_slot('{1'b0, 1'b1, 1'b0, 1'b1});
		send_slot('{1'b0, 1'b1, 1'b0, 1'b0});
		send_slot('{1'b1, 1'b1, 1'b1, 1'b0});
	endtask

	// smallest, zero (out of range: a second every timer slot) and largest rate
	task automatic test_rate_extremes();
		write_tps(7'd1);
		send_slot('{1'b1, 1'b1, 1'b1, 1'b0});
		send_slot('{1'b0, 1'b1, 1'b1, 1'b0});
		send_slot('{1'b1, 1'b1, 1'b1, 1'b1});
		write_tps(7'd0);
		repeat (3) send_slot('{1'b0, 1'b1, 1'b1, 1'b0});
		write_tps(7'd127);
		send_slot('{1'b1, 1'b1, 1'b1, 1'b0});
		send_slot('{1'b1, 1'b1, 1'b1, 1'b1});
	endtask

	// runs of timer or counter slots with random content, mostly in one mode
	// so the count climbs; holds, tick soaks and noise mixed in
	task automatic test_random_mix(input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned n_slots);
		int unsigned target;
		int unsigned kind;
		int unsigned len;
		int unsigned pick;
		logic        cur_timer;
		logic        pulse;
		in_item_t    it;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = slots_sent + n_slots;
		cur_timer = 1'($urandom_range(1));
		pulse = 1'b0;
		while (slots_sent < target) begin
			if ($urandom_range(7) == 0) begin
				pick = $urandom_range(99);
				if (pick < 20)
					write_tps(7'd1);
				else if (pick < 30)
					write_tps(7'd127);
				else if (pick < 35)
					write_tps(7'd0);
				else if (pick < 75)
					write_tps(7'($urandom_range(4, 1)));
				else
					write_tps(7'($urandom_range(127, 1)));
			end
			kind = $urandom_range(99);
			if (kind >= 22 && kind < 32)
				cur_timer = ~cur_timer;
			len = (kind >= 18 && kind < 22) ? $urandom_range(160, 100) :
				(kind < 18) ? $urandom_range(15, 3) : $urandom_range(120, 30);
			repeat (len) begin
				it = in_item_t'(4'($urandom));
				if (kind >= 8 && kind < 18) begin
					it.run_on = 1'b0;
				end else if (kind >= 18 && kind < 22) begin
					it.run_on = 1'b0;
					it.tick = 1'b1;
				end else if (kind >= 22) begin
					it.run_on = ($urandom_range(9) != 0);
					it.timer_mode = cur_timer;
					if (cur_timer) begin
						it.tick = ($urandom_range(99) < 80);
					end else begin
						if ($urandom_range(99) < 60)
							pulse = ~pulse;
						it.pulse_level = pulse;
					end
				end
				send_slot(it);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 4; i++)
			cnt_digit[i] = '0;
		cnt_sec = '0;
		acc_ticks = '0;
		in_timer = 1'b1;
		armed = 1'b1;
		scan_pos = '0;
		tps_now = TPS_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_scan();
		test_counter_edges();
		test_rate_extremes();
		test_random_mix(24, 83, 450);
		test_random_mix(83, 24, 450);
		test_random_mix(0, 0, 450);

		wait_drained();
		if (display_q.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $time, display_q.size());
			mismatches++;
		end
		$display("Scanned %0d slots through timer and pulse counting, %0d rate writes,",
			slots_sent, tps_writes);
		$display("under three sender/receiver idle mixes; %0d items checked, %0d errors",
			slots_shown, mismatches);
		if (mismatches == 0)
			$display("timer_counter_segment_display_core test passed");
		else
			$display("timer_counter_segment_display_core test failed");
		$finish;
	end

endmodule
